// ===== rtl/core/s256sh_pkg.sv =====
// Package for the streaming SHA-256 hasher: payload structs, state enum,
// round constants and round helper functions. No dependencies.
package s256sh_pkg;

   localparam int LengthCountBitsDefault = 32;
   localparam int QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } back_state_type;

   localparam logic [7:0] PadByte = 8'h80;

   localparam logic [255:0] InitialHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
            32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
            32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
            32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
            32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
            32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
            32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
            32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
            32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
            32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
            32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== rtl/core/s256sh_queue.sv =====
// Short word queue between the byte front end and the compression back end.
// Depends on s256sh_pkg for the queue depth.
module s256sh_queue
   import s256sh_pkg::*;
#(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);
   localparam int Aw = $clog2(QueueDepth);

   logic [Width-1:0] slot_ff [QueueDepth];
   logic [Aw-1:0]    wr_ff, rd_ff;
   logic [Aw:0]      count_ff;

   assign full     = (count_ff == (Aw+1)'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 1'b1;
         if (pop && !empty) rd_ff <= rd_ff + 1'b1;
         case ({push && !full, pop && !empty})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end
endmodule

// ===== rtl/core/s256sh_back.sv =====
// Back end: block buffer, padding, 64-round compression and digest output.
// Depends on s256sh_pkg for payload types, constants and the state enum.
module s256sh_back
   import s256sh_pkg::*;
#(
   parameter int LengthCountBits = LengthCountBitsDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  req_payload_type q_data,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);
   back_state_type state_ff, state_in;

   logic [31:0] hash_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  fill_ff;
   logic [5:0]  round_ff;
   logic [LengthCountBits-1:0] count_ff;
   // Closing phases: 0 none, 1 pad pending, 2 zero fill and length.
   logic [1:0]  close_ff;
   logic [1:0]  word_ff;
   logic        after_ff;
   // Set while the block being filled is the one that carries the length.
   logic        len_blk_ff;

   logic [7:0]  wr_byte;
   logic        wr_en;
   logic        start_round;
   logic [31:0] w_new, s0, s1, t1, t2, e, a;
   logic [63:0] bits;

   assign bits = 64'(count_ff) << 3;
   assign e = v_ff[4];
   assign a = v_ff[0];
   assign t1 = v_ff[7] + (rotr(e,6) ^ rotr(e,11) ^ rotr(e,25))
             + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_const(round_ff) + w_ff[0];
   assign t2 = (rotr(a,2) ^ rotr(a,13) ^ rotr(a,22))
             + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign s0 = rotr(w_ff[1],7) ^ rotr(w_ff[1],18) ^ (w_ff[1] >> 3);
   assign s1 = rotr(w_ff[14],17) ^ rotr(w_ff[14],19) ^ (w_ff[14] >> 10);
   assign w_new = s1 + w_ff[9] + s0 + w_ff[0];

   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_payload.digest_word = {hash_ff[{word_ff, 1'b0}], hash_ff[{word_ff, 1'b1}]};
   assign rsp_payload.word_index  = word_ff;
   assign rsp_payload.last_word   = (word_ff == 2'd3);

   // Byte feeding in idle (a queued byte, the pad, zero fill, or length) and the next state.
   always_comb begin
      q_pop = 1'b0;
      wr_en = 1'b0;
      wr_byte = 8'h00;
      state_in = state_ff;
      start_round = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (close_ff == 2'd1) begin
               wr_en = 1'b1;
               wr_byte = PadByte;
            end else if (close_ff == 2'd2) begin
               wr_en = 1'b1;
               if (len_blk_ff && fill_ff >= 6'd56)
                  wr_byte = bits[{3'd7 - fill_ff[2:0], 3'b111} -: 8];
            end else if (!q_empty) begin
               q_pop = 1'b1;
               wr_en = q_data.has_byte;
               wr_byte = q_data.data_byte;
            end
            if (wr_en && fill_ff == 6'd63) start_round = 1'b1;
            if (start_round) state_in = ST_ROUND;
         end
         ST_ROUND: if (round_ff == 6'd63) state_in = ST_FOLD;
         ST_FOLD: state_in = after_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT: if (!rsp_stall && word_ff == 2'd3) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en && state_ff == ST_IDLE) begin
         w_ff[fill_ff[5:2]] <= {w_ff[fill_ff[5:2]][23:0], wr_byte};
      end
      if (start_round) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
      end
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         round_ff <= '0;
         count_ff <= '0;
         close_ff <= '0;
         word_ff <= '0;
         after_ff <= 1'b0;
         len_blk_ff <= 1'b0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= InitialHash[255 - 32*i -: 32];
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE) begin
            if (wr_en) fill_ff <= fill_ff + 1'b1;
            if (close_ff == 2'd0 && q_pop) begin
               if (q_data.has_byte && count_ff != '1) count_ff <= count_ff + 1'b1;
               if (q_data.is_last) close_ff <= 2'd1;
            end else if (close_ff == 2'd1) begin
               close_ff <= 2'd2;
               // A pad past slot 55 leaves no room for the length here.
               len_blk_ff <= (fill_ff < 6'd56);
            end
            // The final block is the one whose last slot carries the length.
            if (close_ff == 2'd2 && len_blk_ff && fill_ff == 6'd63) after_ff <= 1'b1;
         end
         if (state_ff == ST_ROUND) round_ff <= round_ff + 1'b1;
         if (state_ff == ST_FOLD) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + v_ff[i];
            if (after_ff) close_ff <= 2'd0;
            else if (close_ff == 2'd2) len_blk_ff <= 1'b1;
         end
         if (state_ff == ST_EMIT && !rsp_stall) begin
            word_ff <= word_ff + 1'b1;
            if (word_ff == 2'd3) begin
               after_ff <= 1'b0;
               len_blk_ff <= 1'b0;
               count_ff <= '0;
               fill_ff <= '0;
               for (int i = 0; i < 8; i++) hash_ff[i] <= InitialHash[255 - 32*i -: 32];
            end
         end
      end
   end
endmodule

// ===== rtl/core/s256sh_front.sv =====
// Front end: takes request words, drops idle words and queues the rest.
// Depends on s256sh_pkg for the request payload type.
module s256sh_front
   import s256sh_pkg::*;
(
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            q_full,
   output logic            q_push
);
   // A word with neither a byte nor the last mark changes nothing.
   assign req_stall = q_full;
   assign q_push = req_valid && !q_full && (req_payload.has_byte || req_payload.is_last);
endmodule

// ===== rtl/core/sha256_stream_hasher_unit.sv =====
// Top level of the streaming SHA-256 hasher.
// Depends on s256sh_pkg and the front, queue and back modules.
//
// Usage: the req channel carries one message word per handshake: a byte,
// a has_byte flag and an is_last flag. A word is taken at a rising edge
// with req_valid high and req_stall low. Words go into a four-entry queue,
// so the sender is stalled only when that queue fills.
// Bytes are packed into a 64-byte block at one byte per cycle while the
// back end is idle. When a block fills, the back end runs 64 rounds (one
// per cycle) on its single round unit, then a fold step, and takes no
// bytes meanwhile. On is_last the pad, zero fill and bit length are
// written one byte a cycle, pausing while a block is compressed, and the
// final block (one or two) is compressed. The digest then leaves on the
// rsp channel as four 64-bit words, index 0 to 3, the last flagged, one
// per cycle unless rsp_stall holds a word, which then stays. Synchronous
// reset restores the initial hash and empties the queue; no clearing pass
// is needed.
module sha256_stream_hasher_unit
   import s256sh_pkg::*;
#(
   parameter int LengthCountBits = LengthCountBitsDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);
   logic            q_full, q_empty, q_push, q_pop;
   req_payload_type q_data;

   s256sh_front u_front (
      .req_valid, .req_stall, .req_payload, .q_full, .q_push);

   s256sh_queue #(.Width($bits(req_payload_type))) u_queue (
      .clock, .reset, .push(q_push), .push_data(req_payload), .full(q_full),
      .pop(q_pop), .pop_data(q_data), .empty(q_empty));

   s256sh_back #(.LengthCountBits(LengthCountBits)) u_back (
      .clock, .reset, .q_empty, .q_data, .q_pop, .rsp_valid, .rsp_stall,
      .rsp_payload);
endmodule

// ===== bench/sha256_stream_hasher_unit_tb.sv =====
// Self-checking bench for the streaming SHA-256 hasher: random message words in,
// digest words out, compared against an in-bench SHA-256 digest calculator.
// Depends on s256sh_pkg and sha256_stream_hasher_unit.
module sha256_stream_hasher_unit_tb
   import s256sh_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CountBits = LengthCountBitsDefault;
   localparam int SettleCycles = 400;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   sha256_stream_hasher_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   // Words waiting to be sent, and digest words the block still owes us.
   req_payload_type msg_words[$];
   rsp_payload_type digest_owed[$];
   int  mismatches = 0;
   bit  hold_sender = 0;     // set by the stimulus to drain before sending more

   // Digest calculator state, kept in the bench's own terms.
   logic [31:0] hash_state[8];
   logic [7:0]  block_bytes[64];
   int unsigned fill_level;
   logic [63:0] msg_bytes;

   localparam logic [31:0] RoundK[64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_digest();
      hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      fill_level = 0;
      msg_bytes = 0;
   endtask

   // One 64-round compression of the current block into the hash state.
   task automatic compress_block();
      logic [31:0] sched[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                     block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
         sched[i] = (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10))
                  + sched[i-7] + sched[i-16]
                  + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3));
      {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
         hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + RoundK[i] + sched[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   // Apply one accepted word; on a closing word, queue the four digest words.
   task automatic predict_digest(req_payload_type w);
      logic [63:0] bit_len;
      rsp_payload_type r;
      if (w.has_byte) begin
         block_bytes[fill_level] = w.data_byte;
         fill_level++;
         // The length counter saturates rather than wrapping.
         if (msg_bytes < ((64'd1 << CountBits) - 1)) msg_bytes++;
         if (fill_level == 64) begin
            compress_block();
            fill_level = 0;
         end
      end
      if (w.is_last) begin
         block_bytes[fill_level] = PadByte;
         fill_level++;
         // No room left for the length field: pad out and spend an extra block.
         if (fill_level > 56) begin
            while (fill_level < 64) block_bytes[fill_level++] = 8'h00;
            compress_block();
            fill_level = 0;
         end
         while (fill_level < 56) block_bytes[fill_level++] = 8'h00;
         bit_len = msg_bytes << 3;
         for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 4; i++) begin
            r.digest_word = {hash_state[2*i], hash_state[2*i+1]};
            r.word_index = 2'(i);
            r.last_word = (i == 3);
            digest_owed.push_back(r);
         end
         restart_digest();
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      mismatches++;
   endtask

   task automatic add_word(logic [7:0] b, bit hb, bit lst);
      req_payload_type w;
      w.data_byte = b;
      w.has_byte = hb;
      w.is_last = lst;
      msg_words.push_back(w);
   endtask

   // A message of n random bytes; the close rides on the last byte or comes bare.
   task automatic add_message(int n);
      bit bare;
      bare = (n == 0) || ($urandom_range(0, 2) == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) add_word(8'($urandom), 1'b0, 1'b0);   // idle word
         add_word(8'($urandom), 1'b1, !bare && (i == n - 1));
      end
      if (bare) add_word(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

   // Driver: bursts of random length, random gaps, and an optional hold for drain.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) void'(msg_words.pop_front());
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (msg_words.size() != 0 && !hold_sender) begin
            req_valid <= 1'b1;
            req_payload <= msg_words[0];
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The prediction runs at acceptance, so it sees exactly what the block took.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) predict_digest(req_payload);
   end

   // Receiver stall pattern: long quiet phases alternate with heavy stalling.
   int stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_phase = (stall_phase + 1) % 300;
         rsp_stall <= (stall_phase < 100) ? 1'b0 : ($urandom_range(0, 2) != 0);
      end
   end

   // Monitor: compare each accepted digest word with the oldest one owed.
   rsp_payload_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_owed.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_payload.digest_word, 0);
         end else begin
            want = digest_owed.pop_front();
            if (rsp_payload.digest_word !== want.digest_word)
               report_mismatch("digest_word", rsp_payload.digest_word, want.digest_word);
            if (rsp_payload.word_index !== want.word_index)
               report_mismatch("word_index", rsp_payload.word_index, want.word_index);
            if (rsp_payload.last_word !== want.last_word)
               report_mismatch("last_word", rsp_payload.last_word, want.last_word);
         end
      end
   end

   initial begin
      restart_digest();
      reset = 1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // Directed: empty message, idle word, extremes of byte values, pad edges.
      add_word(8'h00, 1'b0, 1'b1);
      add_word(8'h5a, 1'b0, 1'b0);
      add_word(8'hff, 1'b1, 1'b1);
      add_word(8'h00, 1'b1, 1'b0);
      add_word(8'h00, 1'b0, 1'b1);
      add_message(58);       // pad lands past slot 55 and forces an extra block
      // Wait until every digest word has come back before going on.
      wait (msg_words.size() == 0 && !req_valid);
      hold_sender = 1;
      wait (digest_owed.size() == 0);
      @(posedge clock);
      hold_sender = 0;

      // Random short messages.
      for (int m = 0; m < 9; m++)
         add_message($urandom_range(0, 10));

      wait (msg_words.size() == 0 && !req_valid);
      wait (digest_owed.size() == 0);
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sha256_stream_hasher_unit.f =====
rtl/core/s256sh_pkg.sv
rtl/core/s256sh_queue.sv
rtl/core/s256sh_back.sv
rtl/core/s256sh_front.sv
rtl/core/sha256_stream_hasher_unit.sv
bench/sha256_stream_hasher_unit_tb.sv
